/* hw/rtl/tcps_pkg.sv */
// Shared types and constants of the token credit priority scheduler.
// Holds the slot table entry, the result record, the sequencer states and codes.
// Depends on nothing; every other file but tcps_ram imports it.
package tcps_pkg;

    // Table size and field widths.
    localparam int NUM_SLOTS  = 32;
    localparam int NUM_QUEUES = 16;
    localparam int ADDR_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = ADDR_W + 1;
    localparam int SLOT_W     = 5;
    localparam int PRIO_W     = 4;
    localparam int QUANT_W    = 16;
    localparam int TOK_W      = 32;
    localparam int TIME_W     = 32;
    localparam int NMP_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int OP_W       = 3;
    localparam int AVAIL_W    = 38;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_QUEUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_QUEUE   = 2'd2;
    localparam logic [15:0]          MAX_TOKENS_RST   = 16'd1000;
    localparam logic [PRIO_W-1:0]    LOWEST_QUEUE_RST = 4'd15;

    // Request codes.
    localparam logic [OP_W-1:0] OP_START   = 3'd0;
    localparam logic [OP_W-1:0] OP_INHERIT = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
    localparam logic [OP_W-1:0] OP_OOQ     = 3'd3;
    localparam logic [OP_W-1:0] OP_NICE    = 3'd4;
    localparam logic [OP_W-1:0] OP_BALANCE = 3'd5;

    // Reply status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_PERM   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_PRIO   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_PARENT = 3'd5;

    // Lowest token count a slot can hold.
    localparam logic signed [33:0] TOK_FLOOR = -34'sd2147483648;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE, S_REFILL, S_REFILL_EX, S_BAL, S_BAL_EX,
        S_SLOT_RD, S_SLOT_EX, S_REPLY, S_FIN
    } t_state;

    // One entry of the slot table memory.
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [PRIO_W-1:0]  max_prio;
        logic [QUANT_W-1:0] slice;
        logic [TOK_W-1:0]   tokens;
        logic [TIME_W-1:0]  last_sys;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One result record.
    typedef struct packed {
        logic                has_command;
        logic [SLOT_W-1:0]   cmd_slot;
        logic                sets_prio;
        logic [PRIO_W-1:0]   cmd_prio;
        logic                sets_quantum;
        logic [QUANT_W-1:0]  cmd_quantum;
        logic                has_reply;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

/* hw/rtl/token_credit_priority_scheduler.sv */
// Token credit priority scheduler: request sequencer and slot table update.
// Depends on tcps_pkg, tcps_ram and tcps_out.
//
// Usage: a request is taken when start is high and busy is low; busy stays
// high until the request has been worked through. Results leave one at a
// time on the o_ ports, each for one cycle with o_valid high; o_last marks
// the final result of a request. The receiver cannot stall, so results are
// never held off. Configuration is written through i_cfg_we, i_cfg_idx and
// i_cfg_data while busy is low.
// Sequence: the slot table is one memory with a registered read. A
// successful start, inherit or nice passes S_SLOT_EX, S_REPLY and S_FIN, a
// stop or a rejected request S_REPLY and S_FIN, an unused request code
// only S_FIN. A refill visits up to NUM_SLOTS slots from the cursor in
// S_REFILL, with S_REFILL_EX for a slot in use; out of quantum then passes
// S_SLOT_RD, S_SLOT_EX if its slot is in use, S_REPLY and S_FIN. A balance
// tick sweeps in S_BAL, with S_BAL_EX for a slot in use, then refills, then
// S_FIN. The last result is on the ports in the first cycle with busy low.
// Reset: in-use flags, refill cursor and refill time clear; the registers take
// their reset values. Table contents are written before they are read.
module token_credit_priority_scheduler
    import tcps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_op,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [SLOT_W-1:0]     i_parent_slot,
    input  logic                  i_is_own_parent,
    input  logic [NMP_W-1:0]      i_new_max_prio,
    input  logic [QUANT_W-1:0]    i_quantum,
    input  logic [TIME_W-1:0]     i_sys_time_total,
    input  logic [TIME_W-1:0]     i_now_ticks,
    input  logic                  i_trusted,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic                  o_has_command,
    output logic [SLOT_W-1:0]     o_cmd_slot,
    output logic                  o_sets_prio,
    output logic [PRIO_W-1:0]     o_cmd_prio,
    output logic                  o_sets_quantum,
    output logic [QUANT_W-1:0]    o_cmd_quantum,
    output logic                  o_has_reply,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_last
);

    t_state                r_state, n_state;
    logic [OP_W-1:0]       r_op;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_slot_ok;
    logic [PRIO_W-1:0]     r_nmp;
    logic [QUANT_W-1:0]    r_quantum;
    logic [TIME_W-1:0]     r_sys;
    logic [TIME_W-1:0]     r_now;
    logic [STATUS_W-1:0]   r_status;
    logic [NUM_SLOTS-1:0]  r_in_use;
    logic [ADDR_W-1:0]     r_cursor;
    logic [TIME_W-1:0]     r_last_refill;
    logic [AVAIL_W-1:0]    r_avail;
    logic [CNT_W-1:0]      r_cnt;
    logic [15:0]           r_max_tokens;
    logic [PRIO_W-1:0]     r_lowest_queue;

    logic                  w_accept;
    logic                  w_slot_ok, w_par_ok, w_nmp_ok;
    logic [SLOT_W-1:0]     w_par;
    logic [ADDR_W-1:0]     w_s_idx, w_par_idx, w_cnt_idx, w_cur_next, w_r_idx;
    t_state                w_dec_state;
    logic [STATUS_W-1:0]   w_dec_status;
    logic                  w_dec_stop;
    logic                  w_ref_go, w_bal_end;
    logic [TIME_W-1:0]     w_refill_diff;

    logic [ADDR_W-1:0]     w_raddr, w_waddr;
    logic [ENTRY_W-1:0]    w_rdata;
    t_entry                w_rd, w_wd;
    logic                  w_we;
    logic                  w_push, w_finish;
    t_result               w_res, w_out_res;

    logic signed [33:0]    w_tok, w_add_raw, w_clamp, w_nt, w_t;
    logic signed [AVAIL_W:0] w_avail_s, w_add_ext, w_avail_left;
    logic [TIME_W-1:0]     w_delta;
    logic [PRIO_W-1:0]     w_prio_dem;

    assign w_accept  = start && !busy;
    assign busy      = (r_state != S_IDLE);

    // Request field checks.
    assign w_par     = i_is_own_parent ? i_slot : i_parent_slot;
    assign w_slot_ok = {1'b0, i_slot} < (SLOT_W + 1)'(NUM_SLOTS);
    assign w_par_ok  = {1'b0, w_par} < (SLOT_W + 1)'(NUM_SLOTS);
    assign w_nmp_ok  = i_new_max_prio < NMP_W'(NUM_QUEUES);
    assign w_s_idx   = i_slot[ADDR_W-1:0];
    assign w_par_idx = w_par[ADDR_W-1:0];
    assign w_cnt_idx = r_cnt[ADDR_W-1:0];
    assign w_r_idx   = r_slot[ADDR_W-1:0];
    assign w_cur_next = (r_cursor == ADDR_W'(NUM_SLOTS - 1)) ? '0 : r_cursor + 1'b1;
    assign w_ref_go  = (r_cnt < CNT_W'(NUM_SLOTS)) && (r_avail != '0);
    assign w_bal_end = (r_cnt == CNT_W'(NUM_SLOTS));
    assign w_refill_diff = (r_state == S_IDLE) ?
                           i_now_ticks - r_last_refill : r_now - r_last_refill;

    // Decode of a new request into its first state and its status.
    always_comb begin
        w_dec_state  = S_REPLY;
        w_dec_status = ST_OK;
        w_dec_stop   = 1'b0;
        case (i_op)
            OP_START, OP_INHERIT: begin
                if (!i_trusted) begin
                    w_dec_status = ST_NOT_PERM;
                end else if (!w_slot_ok) begin
                    w_dec_status = ST_BAD_SLOT;
                end else if (r_in_use[w_s_idx]) begin
                    w_dec_status = ST_BUSY;
                end else if (!w_nmp_ok) begin
                    w_dec_status = ST_BAD_PRIO;
                end else if (i_op == OP_START) begin
                    w_dec_state = S_SLOT_EX;
                end else if (i_is_own_parent || !w_par_ok || !r_in_use[w_par_idx]) begin
                    w_dec_status = ST_BAD_PARENT;
                end else begin
                    w_dec_state = S_SLOT_EX;
                end
            end
            OP_STOP: begin
                if (!i_trusted) begin
                    w_dec_status = ST_NOT_PERM;
                end else if (!w_slot_ok || !r_in_use[w_s_idx]) begin
                    w_dec_status = ST_BAD_SLOT;
                end else begin
                    w_dec_stop = 1'b1;
                end
            end
            OP_OOQ: begin
                w_dec_state = S_REFILL;
            end
            OP_NICE: begin
                if (!i_trusted) begin
                    w_dec_status = ST_NOT_PERM;
                end else if (!w_slot_ok || !r_in_use[w_s_idx]) begin
                    w_dec_status = ST_BAD_SLOT;
                end else if (!w_nmp_ok) begin
                    w_dec_status = ST_BAD_PRIO;
                end else begin
                    w_dec_state = S_SLOT_EX;
                end
            end
            OP_BALANCE: begin
                w_dec_state = S_BAL;
            end
            default: begin
                w_dec_state = S_FIN;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_dec_state;
                end
            end
            S_REFILL: begin
                if (w_ref_go) begin
                    n_state = r_in_use[w_cur_next] ? S_REFILL_EX : S_REFILL;
                end else begin
                    n_state = (r_op == OP_OOQ) ? S_SLOT_RD : S_FIN;
                end
            end
            S_REFILL_EX: n_state = S_REFILL;
            S_BAL: begin
                if (w_bal_end) begin
                    n_state = S_REFILL;
                end else if (r_in_use[w_cnt_idx]) begin
                    n_state = S_BAL_EX;
                end
            end
            S_BAL_EX:  n_state = S_BAL;
            S_SLOT_RD: n_state = (r_slot_ok && r_in_use[w_r_idx]) ? S_SLOT_EX : S_REPLY;
            S_SLOT_EX: n_state = S_REPLY;
            S_REPLY:   n_state = S_FIN;
            S_FIN:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Table read address: the entry the next state works on.
    always_comb begin
        case (r_state)
            S_IDLE:   w_raddr = (i_op == OP_INHERIT) ? w_par_idx : w_s_idx;
            S_REFILL: w_raddr = w_cur_next;
            S_BAL:    w_raddr = w_cnt_idx;
            default:  w_raddr = w_r_idx;
        endcase
    end

    // Arithmetic on the entry just read.
    assign w_rd      = t_entry'(w_rdata);
    assign w_tok     = 34'(signed'(w_rd.tokens));
    assign w_add_raw = $signed({18'b0, r_max_tokens}) - w_tok;
    assign w_avail_s = $signed({1'b0, r_avail});
    assign w_add_ext = (AVAIL_W + 1)'(w_add_raw);
    assign w_clamp   = (w_add_ext > w_avail_s) ? w_avail_s[33:0] : w_add_raw;
    assign w_nt      = w_tok + w_clamp;
    assign w_avail_left = w_avail_s - (AVAIL_W + 1)'(w_clamp);
    assign w_delta   = r_sys - w_rd.last_sys;
    assign w_t       = w_tok - $signed({2'b0, w_delta});
    assign w_prio_dem = (w_rd.prio < r_lowest_queue) ? w_rd.prio + 1'b1 : w_rd.prio;

    // Table write, result push and request end.
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = w_r_idx;
        w_wd     = w_rd;
        w_push   = 1'b0;
        w_finish = 1'b0;
        w_res    = '0;
        case (r_state)
            S_REFILL_EX: begin
                w_we      = 1'b1;
                w_waddr   = r_cursor;
                w_wd.tokens = w_nt[31:0];
                if (w_nt > 0 && w_nt < w_clamp) begin
                    w_push = 1'b1;
                    w_res.has_command  = 1'b1;
                    w_res.cmd_slot     = SLOT_W'(r_cursor);
                    w_res.sets_prio    = 1'b1;
                    w_res.cmd_prio     = w_rd.prio;
                    w_res.sets_quantum = 1'b1;
                    w_res.cmd_quantum  = w_rd.slice;
                end
            end
            S_BAL_EX: begin
                w_waddr = w_cnt_idx;
                if (w_rd.prio > w_rd.max_prio) begin
                    w_we    = 1'b1;
                    w_wd.prio = w_rd.prio - 1'b1;
                    w_push  = 1'b1;
                    w_res.has_command  = 1'b1;
                    w_res.cmd_slot     = SLOT_W'(w_cnt_idx);
                    w_res.sets_prio    = 1'b1;
                    w_res.cmd_prio     = w_rd.prio - 1'b1;
                    w_res.sets_quantum = 1'b1;
                    w_res.cmd_quantum  = w_rd.slice;
                end
            end
            S_SLOT_EX: begin
                w_we   = 1'b1;
                w_push = 1'b1;
                w_res.has_command  = 1'b1;
                w_res.cmd_slot     = r_slot;
                w_res.sets_prio    = 1'b1;
                w_res.sets_quantum = 1'b1;
                case (r_op)
                    OP_START: begin
                        w_wd.prio     = r_nmp;
                        w_wd.max_prio = r_nmp;
                        w_wd.slice    = r_quantum;
                        w_wd.tokens   = TOK_W'(r_max_tokens);
                        w_wd.last_sys = '0;
                    end
                    OP_INHERIT: begin
                        w_wd.max_prio = r_nmp;
                        w_wd.tokens   = TOK_W'(r_max_tokens);
                        w_wd.last_sys = '0;
                    end
                    OP_OOQ: begin
                        w_wd.prio     = w_prio_dem;
                        w_wd.tokens   = (w_t < TOK_FLOOR) ? TOK_FLOOR[31:0] : w_t[31:0];
                        w_wd.last_sys = r_sys;
                        w_res.sets_quantum = (w_t > 0);
                    end
                    default: begin
                        w_wd.prio     = r_nmp;
                        w_wd.max_prio = r_nmp;
                    end
                endcase
                w_res.cmd_prio    = w_wd.prio;
                w_res.cmd_quantum = w_res.sets_quantum ? w_wd.slice : '0;
            end
            S_REPLY: begin
                w_push          = 1'b1;
                w_res.has_reply = 1'b1;
                w_res.status    = r_status;
            end
            S_FIN: begin
                w_finish = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Sequencer state and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_in_use       <= '0;
            r_cursor       <= '0;
            r_last_refill  <= '0;
            r_max_tokens   <= MAX_TOKENS_RST;
            r_lowest_queue <= LOWEST_QUEUE_RST;
        end else begin
            r_state <= n_state;
            // A write to the initial queue index has no visible effect: an own-parent
            // start sets its priority from the request, an own-parent inherit fails.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_TOKENS:   r_max_tokens   <= i_cfg_data;
                    CFG_LOWEST_QUEUE: r_lowest_queue <= i_cfg_data[PRIO_W-1:0];
                    default:          r_lowest_queue <= r_lowest_queue;
                endcase
            end
            if (w_accept && w_dec_stop) begin
                r_in_use[w_s_idx] <= 1'b0;
            end
            if (r_state == S_SLOT_EX && (r_op == OP_START || r_op == OP_INHERIT)) begin
                r_in_use[w_r_idx] <= 1'b1;
            end
            if (r_state == S_REFILL && w_ref_go) begin
                r_cursor <= w_cur_next;
            end
            if ((w_accept && i_op == OP_OOQ) || (r_state == S_BAL && w_bal_end)) begin
                r_last_refill <= (r_state == S_IDLE) ? i_now_ticks : r_now;
            end
        end
    end

    // Request payload and walk registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_op;
            r_slot    <= i_slot;
            r_slot_ok <= w_slot_ok;
            r_nmp     <= i_new_max_prio[PRIO_W-1:0];
            r_quantum <= i_quantum;
            r_sys     <= i_sys_time_total;
            r_now     <= i_now_ticks;
            r_status  <= w_dec_status;
            r_cnt     <= '0;
            r_avail   <= AVAIL_W'(w_refill_diff[TIME_W-1:1]);
        end
        case (r_state)
            S_REFILL: begin
                if (w_ref_go) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_REFILL_EX: begin
                r_avail <= w_avail_left[AVAIL_W-1:0];
            end
            S_BAL: begin
                if (w_bal_end) begin
                    r_cnt   <= '0;
                    r_avail <= AVAIL_W'(w_refill_diff[TIME_W-1:1]);
                end else if (!r_in_use[w_cnt_idx]) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_BAL_EX: begin
                r_cnt <= r_cnt + 1'b1;
            end
            S_SLOT_RD: begin
                if (!(r_slot_ok && r_in_use[w_r_idx])) begin
                    r_status <= ST_BAD_SLOT;
                end
            end
            default: ;
        endcase
    end

    // Slot table.
    tcps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Result stage.
    tcps_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_res    (w_res),
        .i_finish (w_finish),
        .o_valid  (o_valid),
        .o_res    (w_out_res),
        .o_last   (o_last)
    );

    assign o_has_command  = w_out_res.has_command;
    assign o_cmd_slot     = w_out_res.cmd_slot;
    assign o_sets_prio    = w_out_res.sets_prio;
    assign o_cmd_prio     = w_out_res.cmd_prio;
    assign o_sets_quantum = w_out_res.sets_quantum;
    assign o_cmd_quantum  = w_out_res.cmd_quantum;
    assign o_has_reply    = w_out_res.has_reply;
    assign o_status       = w_out_res.status;

`ifndef SYNTHESIS
    // A request never pushes a result in the cycle that ends it.
    a_push_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_finish)) else $error("result pushed at request end");

    // The table is only written while a request is worked on.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> busy) else $error("table write while idle");

    // A result is either a command or a reply.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_has_command != o_has_reply)) else $error("bad result kind");

    // Every accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy) else $error("request dropped");
`endif

endmodule

/* hw/rtl/tcps_ram.sv */
// Generic single write port memory with a registered read port.
// Stand-alone; used for the slot table of the scheduler.
module tcps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/tcps_out.sv */
// Result stage of the scheduler: holds one result back so that the final one
// of a request can be marked. Depends on tcps_pkg.
module tcps_out
    import tcps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_finish,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_last
);

    logic    r_held_v;
    t_result r_held;
    logic    r_valid;
    logic    r_last;
    t_result r_res;

    // Control: a held result leaves when the next arrives or the request ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_held_v && (i_push || i_finish);
            if (i_push) begin
                r_held_v <= 1'b1;
            end else if (i_finish) begin
                r_held_v <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_held <= i_res;
        end
        if (r_held_v && (i_push || i_finish)) begin
            r_res  <= r_held;
            r_last <= !i_push;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

endmodule

/* tb/sv/sched_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the token credit priority scheduler: predicts and compares results.
// Watches the request, configuration and result ports; depends on tcps_pkg.
module sched_result_checker
    import tcps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [OP_W-1:0]       i_op,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [SLOT_W-1:0]     i_parent_slot,
    input  logic                  i_is_own_parent,
    input  logic [NMP_W-1:0]      i_new_max_prio,
    input  logic [QUANT_W-1:0]    i_quantum,
    input  logic [TIME_W-1:0]     i_sys_time_total,
    input  logic [TIME_W-1:0]     i_now_ticks,
    input  logic                  i_trusted,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  o_valid,
    input  logic                  o_has_command,
    input  logic [SLOT_W-1:0]     o_cmd_slot,
    input  logic                  o_sets_prio,
    input  logic [PRIO_W-1:0]     o_cmd_prio,
    input  logic                  o_sets_quantum,
    input  logic [QUANT_W-1:0]    o_cmd_quantum,
    input  logic                  o_has_reply,
    input  logic [STATUS_W-1:0]   o_status,
    input  logic                  o_last,
    output int                    errors,
    output int                    pending
);

    localparam logic [QUANT_W-1:0] DEFAULT_SLICE = 16'd200;

    typedef struct {
        t_result body;
        logic    last;
    } sched_result_t;

    // Shadow copy of the configuration and the slot table.
    logic [15:0]        cap_tokens;
    logic [PRIO_W-1:0]  lowest_queue;
    logic [PRIO_W-1:0]  first_queue;
    logic               live      [NUM_SLOTS];
    logic [PRIO_W-1:0]  prio      [NUM_SLOTS];
    logic [PRIO_W-1:0]  prio_ceil [NUM_SLOTS];
    logic [QUANT_W-1:0] slice     [NUM_SLOTS];
    int                 tok       [NUM_SLOTS];
    logic [TIME_W-1:0]  last_sys  [NUM_SLOTS];
    logic [SLOT_W-1:0]  cursor;
    logic [TIME_W-1:0]  last_refill;

    sched_result_t      expected_results[$];
    int                 item_results;

    assign pending = expected_results.size();

    task automatic report(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic push_result(input t_result body);
        sched_result_t r;
        r.body = body;
        r.last = 1'b0;
        expected_results.push_back(r);
        item_results++;
    endtask

    task automatic push_command(input logic [SLOT_W-1:0] s, input logic with_quantum);
        t_result b;
        b = '0;
        b.has_command  = 1'b1;
        b.cmd_slot     = s;
        b.sets_prio    = 1'b1;
        b.cmd_prio     = prio[s];
        b.sets_quantum = with_quantum;
        b.cmd_quantum  = with_quantum ? slice[s] : '0;
        push_result(b);
    endtask

    task automatic push_reply(input logic [STATUS_W-1:0] st);
        t_result b;
        b = '0;
        b.has_reply = 1'b1;
        b.status    = st;
        push_result(b);
    endtask

    // Deal elapsed credits round-robin from the cursor, capping every live slot.
    task automatic deal_credits(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] span;
        longint            avail;
        longint            add;
        longint            nt;
        int                i;
        span        = now - last_refill;
        avail       = longint'(span >> 1);
        last_refill = now;
        i           = 0;
        while (i < NUM_SLOTS && avail > 0) begin
            i++;
            cursor = cursor + 1'b1;
            if (live[cursor]) begin
                add = longint'(cap_tokens) - longint'(tok[cursor]);
                if (add > avail)
                    add = avail;
                avail -= add;
                nt = longint'(tok[cursor]) + add;
                tok[cursor] = int'(nt);
                if (nt > 0 && nt < add)
                    push_command(cursor, 1'b1);
            end
        end
    endtask

    // Work out the results of one accepted request.
    task automatic predict_request();
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] par;
        logic [TIME_W-1:0] delta;
        longint            t;
        s = i_slot;
        item_results = 0;
        case (i_op)
            OP_START, OP_INHERIT: begin
                if (!i_trusted) begin
                    push_reply(ST_NOT_PERM);
                end else if (live[s]) begin
                    push_reply(ST_BUSY);
                end else if (i_new_max_prio >= NUM_QUEUES) begin
                    push_reply(ST_BAD_PRIO);
                end else begin
                    par          = i_is_own_parent ? s : i_parent_slot;
                    tok[s]       = int'({16'd0, cap_tokens});
                    last_sys[s]  = '0;
                    prio_ceil[s] = i_new_max_prio[PRIO_W-1:0];
                    if (i_is_own_parent) begin
                        prio[s]  = first_queue;
                        slice[s] = DEFAULT_SLICE;
                    end
                    if (i_op == OP_START) begin
                        prio[s]  = i_new_max_prio[PRIO_W-1:0];
                        slice[s] = i_quantum;
                        live[s]  = 1'b1;
                        push_command(s, 1'b1);
                        push_reply(ST_OK);
                    end else if (!live[par]) begin
                        push_reply(ST_BAD_PARENT);
                    end else begin
                        prio[s]  = prio[par];
                        slice[s] = slice[par];
                        live[s]  = 1'b1;
                        push_command(s, 1'b1);
                        push_reply(ST_OK);
                    end
                end
            end
            OP_STOP: begin
                if (!i_trusted) begin
                    push_reply(ST_NOT_PERM);
                end else if (!live[s]) begin
                    push_reply(ST_BAD_SLOT);
                end else begin
                    live[s] = 1'b0;
                    push_reply(ST_OK);
                end
            end
            OP_OOQ: begin
                deal_credits(i_now_ticks);
                if (!live[s]) begin
                    push_reply(ST_BAD_SLOT);
                end else begin
                    if (prio[s] < lowest_queue)
                        prio[s] = prio[s] + 1'b1;
                    delta = i_sys_time_total - last_sys[s];
                    t = longint'(tok[s]) - longint'(delta);
                    if (t < -64'sd2147483648)
                        t = -64'sd2147483648;
                    tok[s]      = int'(t);
                    last_sys[s] = i_sys_time_total;
                    push_command(s, t > 0);
                    push_reply(ST_OK);
                end
            end
            OP_NICE: begin
                if (!i_trusted) begin
                    push_reply(ST_NOT_PERM);
                end else if (!live[s]) begin
                    push_reply(ST_BAD_SLOT);
                end else if (i_new_max_prio >= NUM_QUEUES) begin
                    push_reply(ST_BAD_PRIO);
                end else begin
                    prio[s]      = i_new_max_prio[PRIO_W-1:0];
                    prio_ceil[s] = i_new_max_prio[PRIO_W-1:0];
                    push_command(s, 1'b1);
                    push_reply(ST_OK);
                end
            end
            OP_BALANCE: begin
                // Promote every demoted slot by one step, then refill.
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (live[i] && prio[i] > prio_ceil[i]) begin
                        prio[i] = prio[i] - 1'b1;
                        push_command(SLOT_W'(i), 1'b1);
                    end
                end
                deal_credits(i_now_ticks);
            end
            default: ;
        endcase
        if (item_results > 0)
            expected_results[$].last = 1'b1;
    endtask

    // Compare one result with the oldest expectation, field by field.
    task automatic check_result();
        sched_result_t e;
        if (expected_results.size() == 0) begin
            $display("%0t: result with no request outstanding", $realtime);
            errors++;
        end else begin
            e = expected_results.pop_front();
            if (o_has_command !== e.body.has_command)
                report("has_command", o_has_command, e.body.has_command);
            if (o_cmd_slot !== e.body.cmd_slot)
                report("cmd_slot", o_cmd_slot, e.body.cmd_slot);
            if (o_sets_prio !== e.body.sets_prio)
                report("sets_prio", o_sets_prio, e.body.sets_prio);
            if (o_cmd_prio !== e.body.cmd_prio)
                report("cmd_prio", o_cmd_prio, e.body.cmd_prio);
            if (o_sets_quantum !== e.body.sets_quantum)
                report("sets_quantum", o_sets_quantum, e.body.sets_quantum);
            if (o_cmd_quantum !== e.body.cmd_quantum)
                report("cmd_quantum", o_cmd_quantum, e.body.cmd_quantum);
            if (o_has_reply !== e.body.has_reply)
                report("has_reply", o_has_reply, e.body.has_reply);
            if (o_status !== e.body.status)
                report("status", o_status, e.body.status);
            if (o_last !== e.last)
                report("last", o_last, e.last);
        end
    endtask

    initial errors = 0;

    // Results are compared before a request taken at the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cap_tokens   = MAX_TOKENS_RST;
            lowest_queue = LOWEST_QUEUE_RST;
            first_queue  = 4'd7;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                live[i]      = 1'b0;
                prio[i]      = '0;
                prio_ceil[i] = '0;
                slice[i]     = '0;
                tok[i]       = int'({16'd0, MAX_TOKENS_RST});
                last_sys[i]  = '0;
            end
            cursor      = '0;
            last_refill = '0;
            expected_results.delete();
        end else begin
            if (o_valid === 1'b1)
                check_result();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_TOKENS:   cap_tokens   = i_cfg_data;
                    CFG_LOWEST_QUEUE: lowest_queue = i_cfg_data[PRIO_W-1:0];
                    CFG_INIT_QUEUE:   first_queue  = i_cfg_data[PRIO_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                predict_request();
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, requests, configuration and verdict.
// Depends on tcps_pkg, token_credit_priority_scheduler and sched_result_checker.
module testbench;
    import tcps_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
    localparam int SETTLE_CYCLES = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       i_op = '0;
    logic [SLOT_W-1:0]     i_slot = '0;
    logic [SLOT_W-1:0]     i_parent_slot = '0;
    logic                  i_is_own_parent = 1'b0;
    logic [NMP_W-1:0]      i_new_max_prio = '0;
    logic [QUANT_W-1:0]    i_quantum = '0;
    logic [TIME_W-1:0]     i_sys_time_total = '0;
    logic [TIME_W-1:0]     i_now_ticks = '0;
    logic                  i_trusted = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_valid;
    logic                  o_has_command;
    logic [SLOT_W-1:0]     o_cmd_slot;
    logic                  o_sets_prio;
    logic [PRIO_W-1:0]     o_cmd_prio;
    logic                  o_sets_quantum;
    logic [QUANT_W-1:0]    o_cmd_quantum;
    logic                  o_has_reply;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_last;
    int                    errors;
    int                    pending;
    int                    idle_pct;
    logic [TIME_W-1:0]     uptime;
    logic [TIME_W-1:0]     sys_clock;

    token_credit_priority_scheduler dut (.*);
    sched_result_checker checker_i (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Present one request and hold it until the block takes it.
    task automatic issue(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                         input logic [SLOT_W-1:0] parent, input logic own,
                         input logic [NMP_W-1:0] nmp, input logic [QUANT_W-1:0] quantum,
                         input logic [TIME_W-1:0] sys, input logic [TIME_W-1:0] now,
                         input logic trusted);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_op             <= op;
        i_slot           <= slot;
        i_parent_slot    <= parent;
        i_is_own_parent  <= own;
        i_new_max_prio   <= nmp;
        i_quantum        <= quantum;
        i_sys_time_total <= sys;
        i_now_ticks      <= now;
        i_trusted        <= trusted;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Let every outstanding result arrive and the block fall quiet.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] cap, input logic [3:0] lowest,
                             input logic [3:0] first);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MAX_TOKENS;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LOWEST_QUEUE;
        i_cfg_data <= {12'd0, lowest};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_INIT_QUEUE;
        i_cfg_data <= {12'd0, first};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One random request, mostly well formed with occasional wild values.
    task automatic random_request();
        int                pick;
        logic [OP_W-1:0]   op;
        logic [NMP_W-1:0]  nmp;
        logic [TIME_W-1:0] sys;
        pick = $urandom_range(0, 99);
        if (pick < 20)      op = OP_START;
        else if (pick < 35) op = OP_INHERIT;
        else if (pick < 45) op = OP_STOP;
        else if (pick < 70) op = OP_OOQ;
        else if (pick < 80) op = OP_NICE;
        else if (pick < 96) op = OP_BALANCE;
        else                op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
        nmp = ($urandom_range(0, 99) < 85) ? NMP_W'($urandom_range(0, 15)) : NMP_W'($urandom);
        if ($urandom_range(0, 99) < 90)
            uptime = uptime + $urandom_range(0, 700);
        else
            uptime = $urandom;
        sys_clock = sys_clock + $urandom_range(0, 1500);
        sys = ($urandom_range(0, 99) < 92) ? sys_clock : $urandom;
        issue(op, SLOT_W'($urandom), SLOT_W'($urandom), $urandom_range(0, 99) < 10, nmp,
              QUANT_W'($urandom), sys, uptime, $urandom_range(0, 99) < 92);
    endtask

    initial begin
        idle_pct  = 0;
        uptime    = '0;
        sys_clock = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed requests under the reset configuration.
        issue(OP_START,   5'd0,  5'd0,  1'b0, 8'd3,   16'hFFFF, 32'd0, 32'd0, 1'b0);
        issue(OP_STOP,    5'd4,  5'd0,  1'b0, 8'd0,   16'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_NICE,    5'd4,  5'd0,  1'b0, 8'd2,   16'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_OOQ,     5'd3,  5'd0,  1'b0, 8'd0,   16'd0, 32'd5, 32'd0, 1'b0);
        issue(OP_START,   5'd0,  5'd0,  1'b0, 8'd16,  16'd9, 32'd0, 32'd0, 1'b1);
        issue(OP_START,   5'd0,  5'd0,  1'b0, 8'd3,   16'hFFFF, 32'd0, 32'd0, 1'b1);
        issue(OP_START,   5'd0,  5'd0,  1'b0, 8'd3,   16'd1, 32'd0, 32'd0, 1'b1);
        issue(OP_INHERIT, 5'd1,  5'd0,  1'b1, 8'd4,   16'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_INHERIT, 5'd2,  5'd5,  1'b0, 8'd4,   16'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_INHERIT, 5'd31, 5'd0,  1'b0, 8'd15,  16'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_NICE,    5'd31, 5'd0,  1'b0, 8'd15,  16'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_NICE,    5'd31, 5'd0,  1'b0, 8'd255, 16'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_NICE,    5'd31, 5'd0,  1'b0, 8'd1,   16'd0, 32'd0, 32'd0, 1'b0);
        issue(OP_OOQ,     5'd0,  5'd0,  1'b0, 8'd0,   16'd0, 32'd300, 32'd100, 1'b1);
        issue(OP_OOQ,     5'd0,  5'd0,  1'b0, 8'd0,   16'd0, 32'hFFFF_FFFF, 32'd200, 1'b0);
        issue(OP_BALANCE, 5'd0,  5'd0,  1'b0, 8'd0,   16'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
        issue(OP_BALANCE, 5'd0,  5'd0,  1'b0, 8'd0,   16'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
        issue(OP_STOP,    5'd31, 5'd0,  1'b0, 8'd0,   16'd0, 32'd0, 32'd0, 1'b0);
        issue(OP_STOP,    5'd31, 5'd0,  1'b0, 8'd0,   16'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_SPARE6,  5'd1,  5'd1,  1'b1, 8'hFF,  16'hFFFF, 32'hFFFF_FFFF, 32'd0, 1'b1);
        issue(OP_SPARE7,  5'd2,  5'd2,  1'b0, 8'd0,   16'd0, 32'd0, 32'd0, 1'b0);
        issue(OP_START,   5'd31, 5'd0,  1'b0, 8'd0,   16'd0, 32'd0, 32'd0, 1'b1);
        drain();

        // Random phases, each under its own configuration and idling pattern.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    configure(16'd1, 4'd0, 4'd0);
                    idle_pct = 31;
                end
                1: begin
                    configure(16'hFFFF, 4'd15, 4'd15);
                    idle_pct = 82;
                end
                default: begin
                    configure(16'($urandom_range(2, 5000)), 4'($urandom), 4'($urandom));
                    idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 150; n++)
                random_request();
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
